// ----- hdl/mel_pkg.sv -----
// Shared types, codes and constants of the MIDI event logger.
package mel_pkg;

    localparam int LOG_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [7:0] MIDI_SYSTEM   = 8'hF0;
    localparam logic [7:0] MIDI_STATUS   = 8'h80;
    localparam logic [2:0] CLOCK_LAST    = 3'd5;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_CTRL     = 4'hB;
    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_PRESSURE = 4'hD;
    localparam logic [3:0] TYPE_BEND     = 4'hE;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_OFF    = 3'd2;
    localparam logic [2:0] ACT_OVER   = 3'd3;
    localparam logic [2:0] ACT_CLOCK  = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_PARSE,
        OP_WALK,
        OP_RD_RES,
        OP_BACK,
        OP_EDIT,
        OP_SCAN,
        OP_SCAN_RES,
        OP_APPEND,
        OP_EMIT
    } mel_op_t;

    typedef enum logic [1:0] {
        K_OTHER,
        K_READ,
        K_MSG
    } mel_kind_t;

    typedef struct packed {
        mel_op_t op;
    } mel_cmd_t;

    typedef struct packed {
        mel_kind_t kind;
        logic      msg_off;
        logic      count_zero;
        logic      clr_done;
        logic      walk_done;
        logic      scan_done;
        logic      scan_hit;
        logic      edit_other;
        logic      edit_back;
        logic      edit_match;
        logic      emit_ok;
    } mel_status_t;

endpackage

// ----- hdl/mel_ctrl.sv -----
// Sequencer of the MIDI event logger: steps the datapath through each beat.
module mel_ctrl import mel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mel_status_t status,
    output mel_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_RD,
        S_RD_RES,
        S_EDIT_RD,
        S_EDIT_CHK,
        S_EDIT_BACK,
        S_EDIT_WR,
        S_SCAN,
        S_SCAN_RES,
        S_APPEND,
        S_FINISH
    } state_t;

    state_t   state_reg;
    state_t   state_next;
    logic     ready_reg;
    mel_cmd_t cmd_reg;

    function automatic mel_op_t op_of(input state_t s);
        mel_op_t o;
        case (s)
            S_CLEAR:     o = OP_CLR;
            S_IDLE:      o = OP_LOAD;
            S_DECODE:    o = OP_PARSE;
            S_WALK:      o = OP_WALK;
            S_RD_RES:    o = OP_RD_RES;
            S_EDIT_BACK: o = OP_BACK;
            S_EDIT_WR:   o = OP_EDIT;
            S_SCAN:      o = OP_SCAN;
            S_SCAN_RES:  o = OP_SCAN_RES;
            S_APPEND:    o = OP_APPEND;
            S_FINISH:    o = OP_EMIT;
            default:     o = OP_NONE;
        endcase
        return o;
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     if (status.clr_done) state_next = S_IDLE;
            S_IDLE:      if (s_valid && ready_reg) state_next = S_DECODE;
            S_DECODE: begin
                case (status.kind)
                    K_READ:  state_next = S_WALK;
                    K_MSG: begin
                        if (status.count_zero)   state_next = S_APPEND;
                        else if (status.msg_off) state_next = S_SCAN;
                        else                     state_next = S_EDIT_RD;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_WALK:      if (status.walk_done) state_next = S_RD;
            S_RD:        state_next = S_RD_RES;
            S_RD_RES:    state_next = S_FINISH;
            S_EDIT_RD:   state_next = S_EDIT_CHK;
            S_EDIT_CHK: begin
                if (status.edit_other && !status.edit_back) state_next = S_EDIT_BACK;
                else if (status.edit_match)                 state_next = S_EDIT_WR;
                else                                        state_next = S_APPEND;
            end
            S_EDIT_BACK: state_next = S_EDIT_RD;
            S_EDIT_WR:   state_next = S_FINISH;
            S_SCAN: begin
                if (status.scan_done) state_next = status.scan_hit ? S_SCAN_RES : S_APPEND;
            end
            S_SCAN_RES:  state_next = S_FINISH;
            S_APPEND:    state_next = S_FINISH;
            S_FINISH:    if (status.emit_ok) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            ready_reg  <= 1'b0;
            cmd_reg.op <= OP_CLR;
        end else begin
            state_reg  <= state_next;
            ready_reg  <= (state_next == S_IDLE);
            cmd_reg.op <= op_of(state_next);
        end
    end

    assign s_ready = ready_reg;
    assign cmd     = cmd_reg;

endmodule

// ----- hdl/mel_datapath.sv -----
// Parsers, event log memory and result register of the MIDI event logger.
module mel_datapath import mel_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_cmd,
    input  logic        s_source,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_now,
    input  logic [5:0]  s_age,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [31:0] m_ev_time,
    output logic [3:0]  m_ev_type,
    output logic [3:0]  m_ev_channel,
    output logic [7:0]  m_ev_first,
    output logic [7:0]  m_ev_second,
    output logic        m_ev_source,
    output logic [6:0]  m_entries_held,
    output logic [5:0]  m_entry_index,
    input  mel_cmd_t    cmd,
    output mel_status_t status
);

    localparam int IW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam logic [IW-1:0] LAST    = IW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LOG_DEPTH);
    localparam logic [IW:0]   SCAN_END = (IW + 1)'(LOG_DEPTH);

    typedef struct packed {
        logic [TIME_BITS-1:0] tstamp;
        logic [3:0]           typ;
        logic [3:0]           chan;
        logic [7:0]           first;
        logic [7:0]           second;
        logic                 src;
    } entry_t;

    entry_t mem [LOG_DEPTH];
    entry_t rd_data_reg;

    logic                 in_cmd_reg;
    logic                 in_src_reg;
    logic [7:0]           in_byte_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic [5:0]           in_age_reg;

    logic [7:0] pend_reg  [2];
    logic       seen_reg  [2];
    logic [7:0] first_reg [2];
    logic [2:0] div_reg   [2];

    logic [7:0] msg_st_reg;
    logic [7:0] msg_v1_reg;
    logic [7:0] msg_v2_reg;

    logic [IW-1:0] newest_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] ptr_reg;
    logic [5:0]    cnt_reg;
    logic [IW:0]   ctr_reg;
    logic          vld_reg;
    logic [IW-1:0] scan_addr_reg;
    logic          hit_reg;
    logic          back_reg;
    logic [IW-1:0] last_idx_reg;
    entry_t        last_entry_reg;

    logic [2:0]    res_action_reg;
    entry_t        res_entry_reg;
    logic [IW-1:0] res_idx_reg;
    logic          res_zero_reg;

    logic          m_valid_reg;
    logic [2:0]    out_action_reg;
    entry_t        out_entry_reg;
    logic [IW-1:0] out_idx_reg;
    logic [CW-1:0] out_held_reg;

    logic [TIME_BITS+31:0] now_ext;
    logic [TIME_BITS-1:0]  now_fit;
    logic [7:0]    st;
    logic [3:0]    st_type;
    logic          one_byte;
    logic          is_msg;
    logic          is_clock_pulse;
    mel_kind_t     kind;
    logic [7:0]    v1;
    logic [7:0]    v2;
    logic [3:0]    msg_type;
    logic [3:0]    msg_ch;
    logic [IW-1:0] ptr_dec;
    logic [IW-1:0] newest_inc;
    logic          scan_hit_now;
    logic          edit_match;
    logic          emit_ok;
    logic          age_beyond;
    entry_t        marked;
    entry_t        edited;
    entry_t        new_entry;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic [IW-1:0] rd_addr;
    logic          m_valid_next;

    assign now_ext = {{TIME_BITS{1'b0}}, s_now};
    assign now_fit = now_ext[TIME_BITS-1:0];

    assign st       = pend_reg[in_src_reg];
    assign st_type  = st[7:4];
    assign one_byte = (st_type == TYPE_PROGRAM) || (st_type == TYPE_PRESSURE);
    assign is_msg   = !in_cmd_reg && (in_byte_reg < MIDI_STATUS) && (st != 8'd0) &&
                      (seen_reg[in_src_reg] || one_byte);
    assign is_clock_pulse = (in_byte_reg == MIDI_CLOCK) &&
                            (div_reg[in_src_reg] == CLOCK_LAST);
    assign kind = in_cmd_reg ? K_READ : (is_msg ? K_MSG : K_OTHER);
    assign v1   = seen_reg[in_src_reg] ? first_reg[in_src_reg] : in_byte_reg;
    assign v2   = seen_reg[in_src_reg] ? in_byte_reg : 8'd0;

    assign msg_type   = msg_st_reg[7:4];
    assign msg_ch     = msg_st_reg[3:0];
    assign ptr_dec    = (ptr_reg == '0) ? LAST : ptr_reg - 1'b1;
    assign newest_inc = (newest_reg == LAST) ? '0 : newest_reg + 1'b1;
    assign emit_ok    = !m_valid_reg || m_ready;
    assign age_beyond = {{CW{1'b0}}, in_age_reg} >= {6'd0, count_reg};

    assign scan_hit_now = vld_reg && (rd_data_reg.typ == TYPE_NOTE_ON) &&
                          (rd_data_reg.first == msg_v1_reg) &&
                          (rd_data_reg.chan == msg_ch) && (rd_data_reg.src == in_src_reg);
    assign edit_match = (rd_data_reg.chan == msg_ch) && (rd_data_reg.src == in_src_reg) &&
                        (rd_data_reg.typ == msg_type) &&
                        (((msg_type == TYPE_CTRL) && (rd_data_reg.first == msg_v1_reg)) ||
                         (msg_type == TYPE_BEND) || (msg_type == TYPE_PRESSURE));

    always_comb begin
        marked        = rd_data_reg;
        marked.typ    = TYPE_NOTE_OFF;
        marked.tstamp = in_now_reg;
        edited        = rd_data_reg;
        edited.tstamp = in_now_reg;
        edited.first  = msg_v1_reg;
        edited.second = msg_v2_reg;
        new_entry     = '{tstamp: in_now_reg, typ: msg_type, chan: msg_ch,
                          first: msg_v1_reg, second: msg_v2_reg, src: in_src_reg};
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = '0;
        case (cmd.op)
            OP_CLR: begin
                wr_en = 1'b1;
            end
            OP_SCAN: begin
                wr_en   = scan_hit_now;
                wr_addr = scan_addr_reg;
                wr_data = marked;
            end
            OP_EDIT: begin
                wr_en   = 1'b1;
                wr_data = edited;
            end
            OP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = newest_inc;
                wr_data = new_entry;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign rd_addr = (cmd.op == OP_SCAN) ? ctr_reg[IW-1:0] : ptr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        if (cmd.op == OP_EMIT && emit_ok) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                pend_reg[i] <= 8'd0;
                seen_reg[i] <= 1'b0;
                div_reg[i]  <= 3'd0;
            end
            newest_reg  <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            ctr_reg     <= '0;
            vld_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            back_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (cmd.op)
                OP_CLR: begin
                    ptr_reg <= (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
                end
                OP_PARSE: begin
                    ptr_reg  <= newest_reg;
                    ctr_reg  <= '0;
                    vld_reg  <= 1'b0;
                    hit_reg  <= 1'b0;
                    back_reg <= 1'b0;
                    if (!in_cmd_reg) begin
                        if (in_byte_reg == MIDI_CLOCK) begin
                            div_reg[in_src_reg] <= is_clock_pulse ? 3'd0 :
                                                   div_reg[in_src_reg] + 3'd1;
                        end else if (in_byte_reg >= MIDI_SYSTEM) begin
                            pend_reg[in_src_reg] <= pend_reg[in_src_reg];
                        end else if (in_byte_reg >= MIDI_STATUS) begin
                            pend_reg[in_src_reg] <= in_byte_reg;
                            seen_reg[in_src_reg] <= 1'b0;
                        end else if (is_msg) begin
                            pend_reg[in_src_reg] <= 8'd0;
                            seen_reg[in_src_reg] <= 1'b0;
                        end else if (st != 8'd0) begin
                            seen_reg[in_src_reg] <= 1'b1;
                        end
                    end
                end
                OP_WALK: begin
                    if (cnt_reg != 6'd0) begin
                        ptr_reg <= ptr_dec;
                    end
                end
                OP_BACK: begin
                    ptr_reg  <= ptr_dec;
                    back_reg <= 1'b1;
                end
                OP_SCAN: begin
                    vld_reg <= (ctr_reg != SCAN_END);
                    if (ctr_reg != SCAN_END) begin
                        ctr_reg <= ctr_reg + 1'b1;
                    end
                    if (scan_hit_now) begin
                        hit_reg <= 1'b1;
                    end
                end
                OP_APPEND: begin
                    newest_reg <= newest_inc;
                    if (count_reg != DEPTH_C) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default: ptr_reg <= ptr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_cmd_reg  <= s_cmd;
                in_src_reg  <= s_source;
                in_byte_reg <= s_data_byte;
                in_now_reg  <= now_fit;
                in_age_reg  <= s_age;
            end
            OP_PARSE: begin
                cnt_reg        <= in_age_reg;
                msg_st_reg     <= st;
                msg_v1_reg     <= v1;
                msg_v2_reg     <= v2;
                res_action_reg <= is_clock_pulse && !in_cmd_reg ? ACT_CLOCK : ACT_NONE;
                res_zero_reg   <= 1'b1;
                res_idx_reg    <= '0;
                if (!in_cmd_reg && in_byte_reg < MIDI_STATUS && st != 8'd0 &&
                    !seen_reg[in_src_reg] && !one_byte) begin
                    first_reg[in_src_reg] <= in_byte_reg;
                end
            end
            OP_WALK: begin
                if (cnt_reg != 6'd0) begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            OP_RD_RES: begin
                res_action_reg <= ACT_READ;
                res_entry_reg  <= rd_data_reg;
                res_idx_reg    <= ptr_reg;
                res_zero_reg   <= age_beyond;
            end
            OP_SCAN: begin
                scan_addr_reg <= ctr_reg[IW-1:0];
                if (scan_hit_now) begin
                    last_idx_reg   <= scan_addr_reg;
                    last_entry_reg <= marked;
                end
            end
            OP_SCAN_RES: begin
                res_action_reg <= ACT_OFF;
                res_entry_reg  <= last_entry_reg;
                res_idx_reg    <= last_idx_reg;
                res_zero_reg   <= 1'b0;
            end
            OP_EDIT: begin
                res_action_reg <= ACT_OVER;
                res_entry_reg  <= edited;
                res_idx_reg    <= ptr_reg;
                res_zero_reg   <= 1'b0;
            end
            OP_APPEND: begin
                res_action_reg <= ACT_APPEND;
                res_entry_reg  <= new_entry;
                res_idx_reg    <= newest_inc;
                res_zero_reg   <= 1'b0;
            end
            OP_EMIT: begin
                if (emit_ok) begin
                    out_action_reg <= res_action_reg;
                    out_entry_reg  <= res_zero_reg ? '0 : res_entry_reg;
                    out_idx_reg    <= res_idx_reg;
                    out_held_reg   <= count_reg;
                end
            end
            default: out_idx_reg <= out_idx_reg;
        endcase
    end

    logic [TIME_BITS+31:0] time_ext;
    logic [IW+5:0]         idx_ext;
    logic [CW+6:0]         held_ext;

    assign time_ext = {32'd0, out_entry_reg.tstamp};
    assign idx_ext  = {6'd0, out_idx_reg};
    assign held_ext = {7'd0, out_held_reg};

    assign m_valid        = m_valid_reg;
    assign m_action       = out_action_reg;
    assign m_ev_time      = time_ext[31:0];
    assign m_ev_type      = out_entry_reg.typ;
    assign m_ev_channel   = out_entry_reg.chan;
    assign m_ev_first     = out_entry_reg.first;
    assign m_ev_second    = out_entry_reg.second;
    assign m_ev_source    = out_entry_reg.src;
    assign m_entries_held = held_ext[6:0];
    assign m_entry_index  = idx_ext[5:0];

    always_comb begin
        status.kind       = kind;
        status.msg_off    = (st_type == TYPE_NOTE_OFF);
        status.count_zero = (count_reg == '0);
        status.clr_done   = (ptr_reg == LAST);
        status.walk_done  = (cnt_reg == 6'd0);
        status.scan_done  = (ctr_reg == SCAN_END) && !vld_reg;
        status.scan_hit   = hit_reg;
        status.edit_other = (rd_data_reg.src != in_src_reg);
        status.edit_back  = back_reg;
        status.edit_match = edit_match;
        status.emit_ok    = emit_ok;
    end

endmodule

// ----- hdl/midi_event_logger_top.sv -----
// Top level of the MIDI event logger: sequencer plus datapath.
//
// Input channel (s_*): one beat is either a MIDI byte push (s_cmd 0) from
// serial or USB (s_source), or a log read by age (s_cmd 1). Result channel
// (m_*): exactly one beat per input beat, in order.
// Work per beat, from acceptance to result valid:
//   plain byte, clock byte, status byte: parsed only
//   message: appended, or an edit of a recent entry
//   note off: a sweep over the log memory, one entry read and possibly
//     rewritten per cycle
//   read: stepping back s_age entries, one entry per cycle
// One beat is worked on at a time; the next can be taken in the cycle after
// the result is loaded into the output register, even while it still waits.
// Reset clears parsers, counters and output valid; then a clearing pass
// zeros every log entry, during which s_ready stays low.
// When the receiver stalls, the result holds and the block waits with the
// next result until the output register frees.
module midi_event_logger_top import mel_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic        s_source,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_now,
    input  logic [5:0]  s_age,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [31:0] m_ev_time,
    output logic [3:0]  m_ev_type,
    output logic [3:0]  m_ev_channel,
    output logic [7:0]  m_ev_first,
    output logic [7:0]  m_ev_second,
    output logic        m_ev_source,
    output logic [6:0]  m_entries_held,
    output logic [5:0]  m_entry_index
);

    mel_cmd_t    cmd;
    mel_status_t status;

    mel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mel_datapath #(
        .LOG_DEPTH (LOG_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cmd          (s_cmd),
        .s_source       (s_source),
        .s_data_byte    (s_data_byte),
        .s_now          (s_now),
        .s_age          (s_age),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_ev_time      (m_ev_time),
        .m_ev_type      (m_ev_type),
        .m_ev_channel   (m_ev_channel),
        .m_ev_first     (m_ev_first),
        .m_ev_second    (m_ev_second),
        .m_ev_source    (m_ev_source),
        .m_entries_held (m_entries_held),
        .m_entry_index  (m_entry_index),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ----- hdl/mel_checker.sv -----
// Port-level checks of the MIDI event logger, bound to the top level.
module mel_checker import mel_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_action,
    input logic [31:0] m_ev_time,
    input logic [3:0]  m_ev_type,
    input logic [6:0]  m_entries_held,
    input logic [5:0]  m_entry_index
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("outputs active after reset");

    a_no_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_NONE || m_action == ACT_CLOCK) |->
        m_ev_time == 32'd0 && m_ev_type == 4'd0 && m_entry_index == 6'd0)
        else $error("non-zero fields on a beat with nothing to report");

    a_write_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_APPEND || m_action == ACT_OVER || m_action == ACT_OFF) |->
        m_entries_held != 7'd0 && m_ev_type >= TYPE_NOTE_OFF)
        else $error("log write reported with empty log or bad type");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ACT_READ && m_entries_held == 7'd0 |-> m_ev_type == 4'd0)
        else $error("read of empty log returned an entry");

endmodule

bind midi_event_logger_top mel_checker u_mel_checker (.*);
